>>> rtl/r2y_pkg.sv
// Shared types and constants for the RGB565 pair to YUY2 converter.
// No dependencies; imported by r2y_pixel_conv and rgb565_pair_to_yuy2_top.
package r2y_pkg;

	// Transaction payloads
	typedef struct packed {
		logic [15:0] pixel_left;
		logic [15:0] pixel_right;
	} pix_pair_t;

	typedef struct packed {
		logic [7:0] luma_left;
		logic [7:0] chroma_blue;
		logic [7:0] luma_right;
		logic [7:0] chroma_red;
	} yuy2_t;

	// Per-pixel converted values, clamped to 0..255
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} yuv_t;

	// Load enables of the four conversion stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// BT.601 studio-range coefficients, 16 fraction bits
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 24;
	localparam int SUM_W     = 26;

	localparam logic [15:0] CY_R = 16'd16843;
	localparam logic [15:0] CY_G = 16'd33030;
	localparam logic [15:0] CY_B = 16'd6423;
	localparam logic [15:0] CU_R = 16'd9699;
	localparam logic [15:0] CU_G = 16'd19071;
	localparam logic [15:0] CU_B = 16'd28770;
	localparam logic [15:0] CV_R = 16'd28770;
	localparam logic [15:0] CV_G = 16'd24117;
	localparam logic [15:0] CV_B = 16'd4653;

	// Offsets scaled to the fixed-point sum
	localparam logic signed [SUM_W-1:0] OFF_Y_FX = SUM_W'(16 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0] OFF_C_FX = SUM_W'(128 << FRAC_BITS);

endpackage

>>> rtl/r2y_pixel_conv.sv
// Four-stage RGB565 to Y/U/V conversion of a single pixel.
// Depends on r2y_pkg; stage load enables come from the top-level pipeline control.
module r2y_pixel_conv (
	input  logic               clk,
	input  r2y_pkg::stage_en_t en,
	input  logic [15:0]        pixel,
	output r2y_pkg::yuv_t      yuv
);
	import r2y_pkg::*;

	logic [7:0]              r_s1, g_s1, b_s1;
	logic [PROD_W-1:0]       yr_s2, yg_s2, yb_s2;
	logic [PROD_W-1:0]       ur_s2, ug_s2, ub_s2;
	logic [PROD_W-1:0]       vr_s2, vg_s2, vb_s2;
	logic signed [SUM_W-1:0] ysum_s3, usum_s3, vsum_s3;
	logic signed [SUM_W-1:0] ysum, usum, vsum;
	yuv_t                    yuv_s4;

	// Floor of the fixed-point sum, clamped to 0..255
	function automatic logic [7:0] clamp_fx(input logic signed [SUM_W-1:0] s);
		logic [7:0] res;
		if (s[SUM_W-1]) begin
			res = 8'd0;
		end else if (|s[SUM_W-2:FRAC_BITS+8]) begin
			res = 8'hFF;
		end else begin
			res = s[FRAC_BITS+7:FRAC_BITS];
		end
		return res;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext(input logic [PROD_W-1:0] p);
		return $signed({{(SUM_W-PROD_W){1'b0}}, p});
	endfunction

	// Stage 1: widen channels to 8 bits by bit replication
	always_ff @(posedge clk) begin
		if (en.s1) begin
			r_s1 <= {pixel[15:11], pixel[15:13]};
			g_s1 <= {pixel[10:5], pixel[10:9]};
			b_s1 <= {pixel[4:0], pixel[4:2]};
		end
	end

	// Stage 2: coefficient products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			yr_s2 <= CY_R * r_s1;
			yg_s2 <= CY_G * g_s1;
			yb_s2 <= CY_B * b_s1;
			ur_s2 <= CU_R * r_s1;
			ug_s2 <= CU_G * g_s1;
			ub_s2 <= CU_B * b_s1;
			vr_s2 <= CV_R * r_s1;
			vg_s2 <= CV_G * g_s1;
			vb_s2 <= CV_B * b_s1;
		end
	end

	// Stage 3: signed sums with offsets
	assign ysum = OFF_Y_FX + ext(yr_s2) + ext(yg_s2) + ext(yb_s2);
	assign usum = OFF_C_FX - ext(ur_s2) - ext(ug_s2) + ext(ub_s2);
	assign vsum = OFF_C_FX + ext(vr_s2) - ext(vg_s2) - ext(vb_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ysum_s3 <= ysum;
			usum_s3 <= usum;
			vsum_s3 <= vsum;
		end
	end

	// Stage 4: floor and clamp
	always_ff @(posedge clk) begin
		if (en.s4) begin
			yuv_s4.y <= clamp_fx(ysum_s3);
			yuv_s4.u <= clamp_fx(usum_s3);
			yuv_s4.v <= clamp_fx(vsum_s3);
		end
	end

	assign yuv = yuv_s4;

endmodule

>>> rtl/rgb565_pair_to_yuy2_top.sv
// Top level of the RGB565 pixel pair to YUY2 converter.
// Depends on r2y_pkg and r2y_pixel_conv (one instance per pixel of the pair).
//
// Converts a pair of RGB565 pixels to one YUY2 pair with BT.601 studio-range
// coefficients. The pipeline takes one pair per clock while pix_ready is high;
// a pair passes four conversion stages (expand, multiply, sum, clamp) and a
// chroma-averaging output register, the first of which loads at the accepting
// edge. Each stage moves forward whenever its successor has room, so bubbles
// fill in under a stalled output and pix_ready drops only when all five stages
// hold data.
module rgb565_pair_to_yuy2_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  r2y_pkg::pix_pair_t pix_data,
	output logic               yuv_valid,
	input  logic               yuv_ready,
	output r2y_pkg::yuy2_t     yuv_data
);
	import r2y_pkg::*;

	logic      valid_s1, valid_s2, valid_s3, valid_s4, valid_q;
	logic      rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	stage_en_t en;
	yuv_t      yuv_l, yuv_r;
	yuy2_t     out_q;
	logic [8:0] u_sum, v_sum;

	// Stage ready: empty or draining into the next stage
	assign rdy_out = !valid_q || yuv_ready;
	assign rdy_s4  = !valid_s4 || rdy_out;
	assign rdy_s3  = !valid_s3 || rdy_s4;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;

	assign pix_ready = rdy_s1;
	assign en.s1 = rdy_s1;
	assign en.s2 = rdy_s2;
	assign en.s3 = rdy_s3;
	assign en.s4 = rdy_s4;

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (rdy_s1)  valid_s1 <= pix_valid;
			if (rdy_s2)  valid_s2 <= valid_s1;
			if (rdy_s3)  valid_s3 <= valid_s2;
			if (rdy_s4)  valid_s4 <= valid_s3;
			if (rdy_out) valid_q  <= valid_s4;
		end
	end

	r2y_pixel_conv u_conv_left (
		.clk   (clk),
		.en    (en),
		.pixel (pix_data.pixel_left),
		.yuv   (yuv_l)
	);

	r2y_pixel_conv u_conv_right (
		.clk   (clk),
		.en    (en),
		.pixel (pix_data.pixel_right),
		.yuv   (yuv_r)
	);

	// Output register: both lumas and the floor average of the pair's chroma
	assign u_sum = {1'b0, yuv_l.u} + {1'b0, yuv_r.u};
	assign v_sum = {1'b0, yuv_l.v} + {1'b0, yuv_r.v};

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_q.luma_left   <= yuv_l.y;
			out_q.chroma_blue <= u_sum[8:1];
			out_q.luma_right  <= yuv_r.y;
			out_q.chroma_red  <= v_sum[8:1];
		end
	end

	assign yuv_valid = valid_q;
	assign yuv_data  = out_q;

	// Backpressure reaches the input only with every stage full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_q && !yuv_ready))
		else $error("input stalled while the pipeline has room");

	// An accepted transaction occupies stage 1 on the next cycle
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> valid_s1)
		else $error("accepted transaction lost at stage 1");

	// A stage that holds data under a stall keeps it
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !rdy_s4 |=> valid_s4)
		else $error("stage 4 dropped a stalled transaction");

	// Studio-range luma stays within 16..235
	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		yuv_valid |-> (yuv_data.luma_left >= 8'd16 && yuv_data.luma_left <= 8'd235 &&
		               yuv_data.luma_right >= 8'd16 && yuv_data.luma_right <= 8'd235))
		else $error("luma out of studio range");

endmodule
